// ===== src/ata_sat_pkg.sv =====
// shared types, constants and codes of the sector address translator
package ata_sat_pkg;

  localparam int BLK_W    = 32;  // request block number
  localparam int LBA_W    = 28;  // addressable sector number of the drive
  localparam int DIV_W    = 11;  // divisor and remainder width (heads * sectors up to 31 * 63)
  localparam int DIV_STEP = 4;   // quotient bits resolved per divider stage
  localparam int CYL_STAGES = (LBA_W + DIV_STEP - 1) / DIV_STEP;
  localparam int SEC_STAGES = (DIV_W + DIV_STEP - 1) / DIV_STEP;
  localparam int Q2_W       = SEC_STAGES * DIV_STEP;
  localparam int CYL_W    = 16;
  localparam int HEAD_W   = 4;
  localparam int SPT_W    = 6;
  localparam int HC_W     = 5;

  localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
  localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
  localparam logic [7:0] DEVICE_BASE       = 8'hE0;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_PART = 2'd1,
    ST_DISK = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PART_START = 3'd0,
    REG_PART_LEN   = 3'd1,
    REG_DISK_SECT  = 3'd2,
    REG_USE_LBA    = 3'd3,
    REG_HEADS      = 3'd4,
    REG_SPT        = 3'd5,
    REG_DRIVE      = 3'd6
  } reg_idx_t;

  // checked request on its way into the divider
  typedef struct packed {
    logic             op;
    status_t          status;
    logic [LBA_W-1:0] lba;
  } req_t;

  // divider constants derived from the geometry registers
  typedef struct packed {
    logic [DIV_W-1:0] per_cyl;
    logic [SPT_W-1:0] spt;
  } geom_t;

  // request with its chs split, sector counted from 0
  typedef struct packed {
    logic              op;
    status_t           status;
    logic [LBA_W-1:0]  lba;
    logic [CYL_W-1:0]  cyl;
    logic [HEAD_W-1:0] head;
    logic [SPT_W-1:0]  sect0;
  } chs_t;

endpackage

// ===== src/ata_sat_check.sv =====
// two-stage front end: partition offset and partition / disk bound checks
module ata_sat_check (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic [ata_sat_pkg::BLK_W-1:0] in_block,
  input  logic [ata_sat_pkg::BLK_W-1:0] partition_start,
  input  logic [ata_sat_pkg::BLK_W-1:0] partition_length,
  input  logic [ata_sat_pkg::LBA_W-1:0] disk_sectors,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ata_sat_pkg::req_t            out_item
);
  import ata_sat_pkg::*;

  logic             s1_valid;
  logic             s1_op;
  logic             s1_part_fail;
  logic [BLK_W-1:0] s1_abs;
  logic             s2_valid;
  req_t             s2_item;

  logic             rdy1;
  logic             rdy2;
  logic [BLK_W:0]   sum;
  logic             part_fail;
  logic             disk_fail;
  status_t          status;

  assign rdy2     = !s2_valid || out_ready;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // read: relative block plus partition start, must stay inside partition and 32 bits
  assign sum       = {1'b0, partition_start} + {1'b0, in_block};
  assign part_fail = (in_op == OP_READ) && ((in_block >= partition_length) || sum[BLK_W]);

  assign disk_fail = s1_abs >= {{(BLK_W-LBA_W){1'b0}}, disk_sectors};

  always_comb begin
    if (s1_part_fail) begin
      status = ST_PART;
    end else if (disk_fail) begin
      status = ST_DISK;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= in_valid;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_op        <= in_op;
      s1_part_fail <= part_fail;
      s1_abs       <= (in_op == OP_WRITE) ? in_block : sum[BLK_W-1:0];
    end
    if (rdy2) begin
      s2_item.op     <= s1_op;
      s2_item.status <= status;
      s2_item.lba    <= s1_abs[LBA_W-1:0];
    end
  end

  assign out_valid = s2_valid;
  assign out_item  = s2_item;

endmodule

// ===== src/ata_sat_chs.sv =====
// pipelined restoring divider: cylinder, then head and sector
module ata_sat_chs (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ata_sat_pkg::req_t  in_item,
  input  ata_sat_pkg::geom_t geom,
  output logic               out_valid,
  input  logic               out_ready,
  output ata_sat_pkg::chs_t  out_item
);
  import ata_sat_pkg::*;

  localparam int NSTG = CYL_STAGES + SEC_STAGES;

  typedef struct packed {
    logic             op;
    status_t          status;
    logic [LBA_W-1:0] lba;
    logic [LBA_W-1:0] q;     // dividend bits still to go, quotient bits shifted in
    logic [DIV_W-1:0] rem;
    logic [Q2_W-1:0]  q2;
    logic [DIV_W-1:0] rem2;
  } dstage_t;

  dstage_t         stg [NSTG];
  dstage_t         stg_next [NSTG];
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  // four dependent compare-and-subtract steps
  function automatic logic [DIV_W+DIV_STEP-1:0] div_step(
    input logic [DIV_W-1:0]    rem_in,
    input logic [DIV_STEP-1:0] bits,
    input logic [DIV_W-1:0]    d
  );
    logic [DIV_W:0]      trial;
    logic [DIV_W-1:0]    r;
    logic [DIV_STEP-1:0] q;
    r = rem_in;
    q = '0;
    for (int k = DIV_STEP - 1; k >= 0; k--) begin
      trial = {r, bits[k]};
      if (trial >= {1'b0, d}) begin
        trial = trial - {1'b0, d};
        q[k]  = 1'b1;
      end
      r = trial[DIV_W-1:0];
    end
    return {r, q};
  endfunction

  always_comb begin
    rdy[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready = rdy[0];

  always_comb begin
    dstage_t                  src;
    logic [DIV_W+DIV_STEP-1:0] res;
    for (int i = 0; i < NSTG; i++) begin
      if (i == 0) begin
        src.op     = in_item.op;
        src.status = in_item.status;
        src.lba    = in_item.lba;
        src.q      = in_item.lba;
        src.rem    = '0;
        src.q2     = '0;
        src.rem2   = '0;
      end else begin
        src = stg[i-1];
      end
      if (i == CYL_STAGES) begin
        // cylinder remainder becomes the dividend of the sector split
        src.q2   = {{(Q2_W-DIV_W){1'b0}}, src.rem};
        src.rem2 = '0;
      end
      if (i < CYL_STAGES) begin
        res      = div_step(src.rem, src.q[LBA_W-1 -: DIV_STEP], geom.per_cyl);
        src.rem  = res[DIV_W+DIV_STEP-1:DIV_STEP];
        src.q    = {src.q[LBA_W-DIV_STEP-1:0], res[DIV_STEP-1:0]};
      end else begin
        res      = div_step(src.rem2, src.q2[Q2_W-1 -: DIV_STEP],
                            {{(DIV_W-SPT_W){1'b0}}, geom.spt});
        src.rem2 = res[DIV_W+DIV_STEP-1:DIV_STEP];
        src.q2   = {src.q2[Q2_W-DIV_STEP-1:0], res[DIV_STEP-1:0]};
      end
      stg_next[i] = src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign out_valid      = vld[NSTG-1];
  assign out_item.op     = stg[NSTG-1].op;
  assign out_item.status = stg[NSTG-1].status;
  assign out_item.lba    = stg[NSTG-1].lba;
  assign out_item.cyl    = stg[NSTG-1].q[CYL_W-1:0];
  assign out_item.head   = stg[NSTG-1].q2[HEAD_W-1:0];
  assign out_item.sect0  = stg[NSTG-1].rem2[SPT_W-1:0];

endmodule

// ===== src/ata_sat_fmt.sv =====
// output register: task-file bytes from the lba or chs split
module ata_sat_fmt (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ata_sat_pkg::chs_t in_item,
  input  logic              use_lba,
  input  logic              drive_select,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [39:0]       out_data
);
  import ata_sat_pkg::*;

  logic [7:0]        sector_byte;
  logic [7:0]        cylinder_low;
  logic [7:0]        cylinder_high;
  logic [7:0]        device_byte;
  logic [7:0]        command_byte;
  logic [HEAD_W-1:0] head;
  logic              valid_q;

  assign in_ready = !valid_q || out_ready;

  always_comb begin
    if (use_lba) begin
      sector_byte   = in_item.lba[7:0];
      cylinder_low  = in_item.lba[15:8];
      cylinder_high = in_item.lba[23:16];
      head          = in_item.lba[27:24];
    end else begin
      sector_byte   = {{(8-SPT_W){1'b0}}, in_item.sect0} + 8'd1;
      cylinder_low  = in_item.cyl[7:0];
      cylinder_high = in_item.cyl[15:8];
      head          = in_item.head;
    end
    device_byte  = DEVICE_BASE | {4'b0000, head} | {3'b000, drive_select, 4'b0000};
    command_byte = (in_item.op == OP_WRITE) ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
    // a failed check sends zeros in every byte
    if (in_item.status != ST_OK) begin
      sector_byte   = '0;
      cylinder_low  = '0;
      cylinder_high = '0;
      device_byte   = '0;
      command_byte  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_status <= in_item.status;
      out_data   <= {command_byte, device_byte, cylinder_high, cylinder_low, sector_byte};
    end
  end

  assign out_valid = valid_q;

endmodule

// ===== src/ata_sector_address_translator.sv =====
// top level: config registers, checks, chs divider and output register
//
// usage
//   s_* channel takes one sector request: s_tuser is the operation (0 read
//   relative to the partition, 1 absolute write), s_tdata the block number.
//   m_* channel returns one task-file result per request, in request order:
//   m_tuser is the status (0 ok, 1 outside partition, 2 beyond disk end),
//   m_tdata the sector, cylinder low, cylinder high, device and command bytes.
//   cfg_* writes one register by index; always ready, to be used only while
//   no request is in flight.
// timing
//   one request per cycle sustained while m_tready stays high; a request
//   passes 2 check stages, 7 cylinder divider stages (4 quotient bits each),
//   3 head/sector divider stages and the output register.
// reset and stall
//   rst empties the pipeline and loads the register defaults (16 heads,
//   63 sectors per track, everything else 0). When m_tready is low, stages
//   fill up behind the output register; s_tready drops only once every
//   stage holds a request, so nothing is lost or repeated.
module ata_sector_address_translator (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block[31:0]
  input  logic        s_tuser,   // op[0]
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // sector_byte[7:0], cylinder_low[15:8], cylinder_high[23:16],
                                 // device_byte[31:24], command_byte[39:32]
  output logic [1:0]  m_tuser,   // status[1:0]
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ata_sat_pkg::*;

  // register file
  logic [BLK_W-1:0]  partition_start;
  logic [BLK_W-1:0]  partition_length;
  logic [LBA_W-1:0]  disk_sectors;
  logic              use_lba;
  logic [HC_W-1:0]   head_count;
  logic [SPT_W-1:0]  sectors_per_track;
  logic              drive_select;

  // geometry with zero treated as one, registered for the divider
  logic [HC_W-1:0]   heads_eff;
  logic [SPT_W-1:0]  spt_eff;
  geom_t             geom;

  // links between stages
  logic              chk_valid;
  logic              chk_ready;
  req_t              chk_item;
  logic              div_valid;
  logic              div_ready;
  chs_t              div_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_start   <= '0;
      partition_length  <= '0;
      disk_sectors      <= '0;
      use_lba           <= 1'b0;
      head_count        <= HC_W'(16);
      sectors_per_track <= SPT_W'(63);
      drive_select      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PART_START: partition_start   <= cfg_data;
        REG_PART_LEN:   partition_length  <= cfg_data;
        REG_DISK_SECT:  disk_sectors      <= cfg_data[LBA_W-1:0];
        REG_USE_LBA:    use_lba           <= cfg_data[0];
        REG_HEADS:      head_count        <= cfg_data[HC_W-1:0];
        REG_SPT:        sectors_per_track <= cfg_data[SPT_W-1:0];
        REG_DRIVE:      drive_select      <= cfg_data[0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  assign heads_eff = (head_count == '0) ? HC_W'(1) : head_count;
  assign spt_eff   = (sectors_per_track == '0) ? SPT_W'(1) : sectors_per_track;

  // sectors per cylinder, ready well before a request reaches the divider
  always_ff @(posedge clk) begin
    geom.per_cyl <= {{(DIV_W-HC_W){1'b0}}, heads_eff} * {{(DIV_W-SPT_W){1'b0}}, spt_eff};
    geom.spt     <= spt_eff;
  end

  ata_sat_check u_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_op            (s_tuser),
    .in_block         (s_tdata),
    .partition_start  (partition_start),
    .partition_length (partition_length),
    .disk_sectors     (disk_sectors),
    .out_valid        (chk_valid),
    .out_ready        (chk_ready),
    .out_item         (chk_item)
  );

  ata_sat_chs u_chs (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_item   (chk_item),
    .geom      (geom),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_item  (div_item)
  );

  ata_sat_fmt u_fmt (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (div_valid),
    .in_ready     (div_ready),
    .in_item      (div_item),
    .use_lba      (use_lba),
    .drive_select (drive_select),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (m_tuser),
    .out_data     (m_tdata)
  );

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench of the ata sector address translator
`timescale 1ns / 1ps

module testbench;
  import ata_sat_pkg::*;

  // cfg index with no register behind it, writes to it must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int unsigned LBA_MAX   = 32'h0FFF_FFFF;

  // what the host queue holds: a sector request, a register write, or a
  // pause until the translator has returned every result
  typedef enum logic [1:0] {
    HC_REQUEST,
    HC_REG_WRITE,
    HC_DRAIN
  } host_kind_t;

  typedef struct {
    host_kind_t  kind;
    logic        op;
    logic [31:0] blk;
    logic [2:0]  idx;
    logic [31:0] data;
    bit          steady;  // no idling on either side while this request is out
  } host_cmd_t;

  // testbench copy of the register file
  typedef struct {
    logic [31:0]      part_start;
    logic [31:0]      part_len;
    logic [LBA_W-1:0] disk_sectors;
    logic             use_lba;
    logic [HC_W-1:0]  heads;
    logic [SPT_W-1:0] spt;
    logic             drive;
  } drive_regs_t;

  typedef struct {
    status_t    status;
    logic [7:0] sector;
    logic [7:0] cyl_lo;
    logic [7:0] cyl_hi;
    logic [7:0] device;
    logic [7:0] command;
  } task_file_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  host_cmd_t   host_cmds[$];
  task_file_t  expected_task_files[$];
  drive_regs_t regs;
  int          err_count = 0;
  logic        req_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  logic        steady = 1'b0;
  bit          plan_steady = 1'b0;

  always #6 clk = ~clk;

  ata_sector_address_translator DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // block[31:0]
    .s_tuser   (s_tuser),    // op[0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // sector, cyl low, cyl high, device, command bytes
    .m_tuser   (m_tuser),    // status[1:0]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // register file and task-file prediction
  // ---------------------------------------------------------------------------

  function automatic void write_drive_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_PART_START: regs.part_start   = data;
      REG_PART_LEN:   regs.part_len     = data;
      REG_DISK_SECT:  regs.disk_sectors = data[LBA_W-1:0];
      REG_USE_LBA:    regs.use_lba      = data[0];
      REG_HEADS:      regs.heads        = data[HC_W-1:0];
      REG_SPT:        regs.spt          = data[SPT_W-1:0];
      REG_DRIVE:      regs.drive        = data[0];
      default: ;
    endcase
  endfunction

  function automatic task_file_t build_task_file(logic op, logic [31:0] blk);
    task_file_t       tf;
    logic [32:0]      abs_blk;
    logic [LBA_W-1:0] lba;
    logic [HC_W-1:0]  h;
    logic [SPT_W-1:0] s;
    logic [DIV_W-1:0] per_cyl;
    logic [LBA_W-1:0] cyl;
    logic [LBA_W-1:0] rem;
    logic [LBA_W-1:0] hd;
    logic [SPT_W-1:0] sect;
    tf = '{status: ST_OK, default: '0};
    // a read is relative to the partition and must stay inside it and inside
    // the 32-bit sector space; this check comes before the disk bound
    if (op == OP_READ) begin
      abs_blk = {1'b0, regs.part_start} + {1'b0, blk};
      if (blk >= regs.part_len || abs_blk[32]) begin
        tf.status = ST_PART;
        return tf;
      end
    end else begin
      abs_blk = {1'b0, blk};
    end
    if (abs_blk >= {5'b0, regs.disk_sectors}) begin
      tf.status = ST_DISK;
      return tf;
    end
    lba = abs_blk[LBA_W-1:0];
    if (regs.use_lba) begin
      tf.sector = lba[7:0];
      tf.cyl_lo = lba[15:8];
      tf.cyl_hi = lba[23:16];
      hd        = {24'b0, lba[27:24]};
    end else begin
      // zero geometry counts as one
      h       = (regs.heads == '0) ? HC_W'(1) : regs.heads;
      s       = (regs.spt == '0) ? SPT_W'(1) : regs.spt;
      per_cyl = h * s;
      cyl     = lba / per_cyl;
      rem     = lba % per_cyl;
      sect    = SPT_W'(rem % s);
      hd      = rem / s;
      tf.sector = 8'(sect) + 8'd1;
      tf.cyl_lo = cyl[7:0];
      tf.cyl_hi = cyl[15:8];
    end
    // head beyond 15 only keeps its low nibble
    tf.device  = DEVICE_BASE | {4'b0, hd[3:0]} | {3'b0, regs.drive, 4'b0};
    tf.command = (op == OP_WRITE) ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
    return tf;
  endfunction

  // ---------------------------------------------------------------------------
  // host side: requests and register writes from the queue, at falling edges
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : host_feed
    logic      req_next;
    logic      cfg_next;
    host_cmd_t cmd;
    req_next = s_tvalid && !req_taken;
    cfg_next = cfg_valid && !cfg_taken;
    if (!rst && !req_next && !cfg_next && host_cmds.size() != 0) begin
      cmd = host_cmds[0];
      case (cmd.kind)
        HC_REQUEST: begin
          // random idle cycles, none inside a steady stretch
          if (cmd.steady || $urandom_range(0, 99) >= 25) begin
            req_next = 1'b1;
            s_tuser <= cmd.op;
            s_tdata <= cmd.blk;
            steady  <= cmd.steady;
            void'(host_cmds.pop_front());
          end
        end
        HC_REG_WRITE: begin
          // registers only change once the pipeline has emptied
          if (expected_task_files.size() == 0) begin
            cfg_next  = 1'b1;
            cfg_index <= cmd.idx;
            cfg_data  <= cmd.data;
            void'(host_cmds.pop_front());
          end
        end
        default: begin
          if (expected_task_files.size() == 0)
            void'(host_cmds.pop_front());
        end
      endcase
    end
    s_tvalid  <= req_next;
    cfg_valid <= cfg_next;
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(0, 99) >= 25);
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes sampled at rising edges
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, exp_val, act_val);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    task_file_t exp_tf;
    req_taken <= s_tvalid && s_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst) begin
      regs <= '{part_start: '0, part_len: '0, disk_sectors: '0, use_lba: 1'b0,
                heads: HC_W'(16), spt: SPT_W'(63), drive: 1'b0};
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_task_files.size() == 0) begin
          $error("task file with no request outstanding: status %0d data 0x%010h",
                 m_tuser, m_tdata);
          err_count++;
        end else begin
          exp_tf = expected_task_files.pop_front();
          check_field("status", 8'(exp_tf.status), 8'(m_tuser));
          check_field("sector_byte", exp_tf.sector, m_tdata[7:0]);
          check_field("cylinder_low", exp_tf.cyl_lo, m_tdata[15:8]);
          check_field("cylinder_high", exp_tf.cyl_hi, m_tdata[23:16]);
          check_field("device_byte", exp_tf.device, m_tdata[31:24]);
          check_field("command_byte", exp_tf.command, m_tdata[39:32]);
        end
      end
      if (s_tvalid && s_tready)
        expected_task_files.push_back(build_task_file(s_tuser, s_tdata));
      if (cfg_valid && cfg_ready)
        write_drive_reg(cfg_index, cfg_data);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_request(logic op, logic [31:0] blk);
    host_cmds.push_back('{kind: HC_REQUEST, op: op, blk: blk, idx: '0, data: '0,
                          steady: plan_steady});
  endtask

  // upper bits beyond the register width carry junk that must be dropped
  task automatic push_reg(logic [2:0] idx, logic [31:0] value, int width);
    logic [31:0] keep;
    keep = (width >= 32) ? '1 : 32'((64'd1 << width) - 1);
    host_cmds.push_back('{kind: HC_REG_WRITE, op: 1'b0, blk: '0, idx: idx,
                          data: (value & keep) | ($urandom() & ~keep), steady: 1'b0});
  endtask

  task automatic push_drain();
    host_cmds.push_back('{kind: HC_DRAIN, op: 1'b0, blk: '0, idx: '0, data: '0,
                          steady: 1'b0});
  endtask

  task automatic push_setup(logic [31:0] start, logic [31:0] len, logic [31:0] disk,
                            logic lba, int heads, int spt, logic drive);
    push_reg(REG_PART_START, start, 32);
    push_reg(REG_PART_LEN, len, 32);
    push_reg(REG_DISK_SECT, disk, LBA_W);
    push_reg(REG_USE_LBA, {31'b0, lba}, 1);
    push_reg(REG_HEADS, heads, HC_W);
    push_reg(REG_SPT, spt, SPT_W);
    push_reg(REG_DRIVE, {31'b0, drive}, 1);
  endtask

  initial begin : stimulus
    int unsigned start, len, disk, pick;
    logic [31:0] blk;
    logic        op;

    // reset defaults: empty partition and zero-sized disk
    push_request(OP_READ, 32'd0);
    push_request(OP_WRITE, 32'd0);

    // lba mode, slave drive, partition of 1000 sectors at 100
    push_setup(100, 1000, LBA_MAX, 1'b1, 16, 63, 1'b1);
    push_request(OP_READ, 32'd0);
    push_request(OP_READ, 32'd999);
    push_request(OP_READ, 32'd1000);
    push_request(OP_WRITE, 32'd0);
    push_request(OP_WRITE, LBA_MAX - 1);
    push_request(OP_WRITE, LBA_MAX);
    push_request(OP_WRITE, 32'hFFFF_FFFF);
    push_request(OP_READ, 32'hFFFF_FFFF);

    // partition near the top of the 32-bit space: disk bound versus wrap
    push_setup(32'hFFFF_FFF0, 32'hFFFF_FFFF, LBA_MAX, 1'b1, 16, 63, 1'b0);
    push_request(OP_READ, 32'd15);
    push_request(OP_READ, 32'd16);

    // chs with the usual 16 x 63 geometry
    push_setup(0, 32'hFFFF_FFFF, LBA_MAX, 1'b0, 16, 63, 1'b0);
    push_request(OP_WRITE, 32'd0);
    push_request(OP_WRITE, 32'd62);
    push_request(OP_WRITE, 32'd63);
    push_request(OP_WRITE, 32'd1007);
    push_request(OP_WRITE, 32'd1008);
    push_request(OP_WRITE, LBA_MAX - 1);
    push_request(OP_READ, 32'd1);

    // zero geometry counts as 1 x 1, cylinder overflows 16 bits
    push_reg(REG_HEADS, 0, HC_W);
    push_reg(REG_SPT, 0, SPT_W);
    push_reg(REG_UNUSED, $urandom(), 32);
    push_request(OP_WRITE, 32'd70000);
    push_request(OP_WRITE, LBA_MAX - 1);

    // more than 16 heads, head number cut to a nibble
    push_setup(0, 32'hFFFF_FFFF, LBA_MAX, 1'b0, 31, 63, 1'b1);
    push_request(OP_WRITE, LBA_MAX - 1);
    push_request(OP_WRITE, 32'd1952);
    push_reg(REG_HEADS, 17, HC_W);
    push_reg(REG_SPT, 1, SPT_W);
    push_request(OP_WRITE, 32'd16);

    // random settings, each followed by a batch of requests shaped to land
    // mostly inside the partition and the disk, with edge and junk blocks
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 3))
        0:       disk = LBA_MAX;
        1:       disk = $urandom_range(1, 4000);
        2:       disk = $urandom() & LBA_MAX;
        default: disk = $urandom_range(0, 2);
      endcase
      case ($urandom_range(0, 3))
        0:       start = 0;
        1:       start = $urandom_range(0, disk);
        2:       start = 32'hFFFF_FFFF - $urandom_range(0, 300);
        default: start = $urandom();
      endcase
      case ($urandom_range(0, 4))
        0:       len = 32'hFFFF_FFFF;
        1:       len = 0;
        default: len = (disk > start) ? $urandom_range(1, disk - start)
                                      : $urandom_range(0, 50);
      endcase
      push_setup(start, len, disk, 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(0, 31),
                 ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 63),
                 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 2) == 0)
        push_reg(REG_UNUSED, $urandom(), 32);
      plan_steady = (phase == 3);
      for (int n = 0; n < 55; n++) begin
        op   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (op == OP_READ) begin
          if (pick < 60 && len != 0)
            blk = $urandom_range(0, len - 1);
          else if (pick < 75)
            blk = len - $urandom_range(0, 2);
          else
            blk = $urandom();
        end else begin
          if (pick < 60 && disk != 0)
            blk = $urandom_range(0, disk - 1);
          else if (pick < 75)
            blk = disk - $urandom_range(0, 2);
          else
            blk = $urandom();
        end
        push_request(op, blk);
        // hold the requests back once until the pipeline has emptied
        if (phase == 5 && n == 27)
          push_drain();
      end
    end
    plan_steady = 1'b0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (host_cmds.size() != 0 || s_tvalid || cfg_valid ||
           expected_task_files.size() != 0);
    // let any stray result show up
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ata_sat_pkg.sv
src/ata_sat_check.sv
src/ata_sat_chs.sv
src/ata_sat_fmt.sv
src/ata_sector_address_translator.sv
verif/testbench.sv
